// File: design/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared codes and types for the positional list: request and status codes,
// the control bundle broadcast to every storage cell.
// ----------------------------------------------------------------------------
package plist_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;

	localparam logic [6:0] CAPACITY_RESET = 7'd64;

	// Entries per group of the registered read tree
	localparam int READ_GROUP = 16;

	typedef struct packed {
		logic ins;  // shift up from op_pos, write new value at op_pos
		logic del;  // shift down from op_pos
	} plist_ctrl_t;

endpackage

// File: design/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list packed from position 0 with insert, get, delete and clear.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, stage 1 then the output register; a
// result-side stall holds both. Throughput: one item per cycle unless the
// result side stalls; every cell shifts in the accept cycle, and the read
// tree (per-group OR, then OR of groups) is a two-register pipeline.
// Reset: entry count cleared, capacity limit set to 64, result pipeline empty.
// Entry contents are left undefined; no clearing pass, items accepted at once.
// ----------------------------------------------------------------------------
module positional_list_insert_delete
	import plist_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [5:0]  position,
	input  logic [31:0] entry_value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] read_value,
	output logic [6:0]  list_length,
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	localparam int CW   = $clog2(DEPTH + 1);       // count width
	localparam int PW   = (CW > 7) ? CW : 7;       // compare width
	localparam int NGRP = (DEPTH + READ_GROUP - 1) / READ_GROUP;

	// ---------------------------------------------------------------- state
	logic [CW-1:0]  count_q;
	logic [6:0]     capacity_q;

	// stage 1: status, length and per-group read partials
	logic           valid_s1;
	logic [1:0]     status_s1;
	logic           rd_en_s1;
	logic [CW-1:0]  len_s1;
	logic [VALUE_WIDTH-1:0] group_s1 [NGRP];

	// output register
	logic           out_valid_q;
	logic [1:0]     status_q;
	logic [31:0]    read_value_q;
	logic [6:0]     list_length_q;

	// ---------------------------------------------------------- handshakes
	logic accept;
	logic adv_s1;

	// Advance stage 1 when the output register is empty or being drained
	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign accept   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------- decode
	logic [PW-1:0] pos_x;
	logic [PW-1:0] count_x;
	logic [PW-1:0] cap_x;
	logic [PW-1:0] eff_cap;
	logic [PW-1:0] op_pos;
	logic          is_ins;
	logic          is_rd;
	logic          full;
	logic          pos_ok;
	logic [1:0]    status_d;
	logic [CW-1:0] count_d;
	plist_ctrl_t   ctrl;

	assign pos_x   = PW'(position);
	assign count_x = PW'(count_q);
	assign cap_x   = PW'(capacity_q);
	// Clamp the limit to the number of cells
	assign eff_cap = (cap_x > PW'(DEPTH)) ? PW'(DEPTH) : cap_x;

	assign is_ins = (req_type == REQ_INSERT);
	assign is_rd  = (req_type == REQ_GET) || (req_type == REQ_DELETE);
	assign full   = (count_x >= eff_cap);
	assign pos_ok = (pos_x < count_x);

	// Insert past the end appends; get and delete address the position as is
	assign op_pos = (is_ins && (pos_x > count_x)) ? count_x : pos_x;

	assign ctrl.ins = accept && is_ins && !full;
	assign ctrl.del = accept && (req_type == REQ_DELETE) && pos_ok;

	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		case (req_type)
			REQ_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			REQ_GET: begin
				if (!pos_ok) begin
					status_d = ST_BADPOS;
				end
			end
			REQ_DELETE: begin
				if (!pos_ok) begin
					status_d = ST_BADPOS;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			REQ_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// ---------------------------------------------------------- cell chain
	logic [VALUE_WIDTH-1:0] new_value;
	logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
	logic [VALUE_WIDTH-1:0] cell_tap   [NGRP*READ_GROUP];

	assign new_value = VALUE_WIDTH'(entry_value);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_v;
		logic [VALUE_WIDTH-1:0] right_v;

		// Cell 0 never shifts up; the last cell holds on a delete
		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_value[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = cell_value[i];
		end else begin : g_mid_r
			assign right_v = cell_value[i+1];
		end

		plist_cell #(
			.VW  (VALUE_WIDTH),
			.PW  (PW),
			.IDX (i)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.op_pos      (op_pos),
			.new_value   (new_value),
			.left_value  (left_v),
			.right_value (right_v),
			.value       (cell_value[i]),
			.tap         (cell_tap[i])
		);
	end

	// Pad the last read group with zero taps
	for (genvar i = DEPTH; i < NGRP*READ_GROUP; i++) begin : g_pad
		assign cell_tap[i] = '0;
	end

	// ---------------------------------------------------------- read tree
	// Level 1: OR of each group's taps, captured at the accept edge so a
	// delete reports the entry as it stood before the shift.
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		logic [VALUE_WIDTH-1:0] grp_or;

		always_comb begin
			grp_or = '0;
			for (int k = 0; k < READ_GROUP; k++) begin
				grp_or = grp_or | cell_tap[g*READ_GROUP + k];
			end
		end

		always_ff @(posedge clk) begin
			if (accept) begin
				group_s1[g] <= grp_or;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			rd_en_s1  <= is_rd && pos_ok;
			len_s1    <= count_d;
		end
	end

	// Level 2: OR across groups, then into the output register
	logic [VALUE_WIDTH-1:0] read_or;

	always_comb begin
		read_or = '0;
		for (int g = 0; g < NGRP; g++) begin
			read_or = read_or | group_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			status_q      <= status_s1;
			// Drop the read for inserts, clears and failed requests
			read_value_q  <= rd_en_s1 ? 32'(read_or) : 32'd0;
			list_length_q <= 7'(len_s1);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign list_length = list_length_q;

	// ---------------------------------------------------------- assertions
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		PW'(count_q) <= PW'(DEPTH))
		else $error("entry count beyond cell count");

	a_full_holds : assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_ins && full) |=> (count_q == $past(count_q)))
		else $error("failed insert changed the count");

	a_fail_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != ST_OK)) |-> (read_value_q == 32'd0))
		else $error("failed request carries a read value");

	a_s1_held : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> valid_s1)
		else $error("stage 1 item lost under stall");

	a_ctrl_excl : assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.ins && ctrl.del))
		else $error("insert and delete shift in the same cycle");

endmodule

// File: design/plist_cell.sv
// ----------------------------------------------------------------------------
// plist_cell
// One list slot. Takes its left neighbor on an insert above the insert point,
// the new value on an insert at it, its right neighbor on a delete at or
// above the delete point, and offers its value on the read tap when addressed.
// ----------------------------------------------------------------------------
module plist_cell
	import plist_pkg::*;
#(
	parameter int VW  = 32,
	parameter int PW  = 7,
	parameter int IDX = 0
) (
	input  logic          clk,
	input  plist_ctrl_t   ctrl,
	input  logic [PW-1:0] op_pos,
	input  logic [VW-1:0] new_value,
	input  logic [VW-1:0] left_value,
	input  logic [VW-1:0] right_value,
	output logic [VW-1:0] value,
	output logic [VW-1:0] tap
);

	localparam logic [PW-1:0] MY_POS = PW'(IDX);

	logic [VW-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && (MY_POS > op_pos)) begin
			value_q <= left_value;
		end else if (ctrl.ins && (MY_POS == op_pos)) begin
			value_q <= new_value;
		end else if (ctrl.del && (MY_POS >= op_pos)) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
	assign tap   = (MY_POS == op_pos) ? value_q : '0;

endmodule

// File: tb/sv/tb_positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// tb_positional_list_insert_delete
// Self-checking bench for the positional list. A walked table of directed
// requests and capacity writes comes first, then random request mixes under
// several capacities. A local copy of the list predicts every result, and
// the results are checked in order, field by field. Both channels idle and
// stall at random, and once the result side holds off long enough to fill
// the pipeline.
// ----------------------------------------------------------------------------
module tb_positional_list_insert_delete
	import plist_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH          = 64;
	localparam int LIMIT_NS       = 400_000;
	localparam int HOLDOFF_CYCLES = 60;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PLAN_LEN       = 29;

	// One line of the directed plan: either a capacity write or a request,
	// with the result typed in where it is obvious.
	typedef struct packed {
		logic        is_cfg;
		logic [6:0]  cap;
		logic [1:0]  req;
		logic [5:0]  pos;
		logic [31:0] val;
		logic        typed;
		logic [1:0]  st;
		logic [31:0] rd;
		logic [6:0]  len;
	} plan_row_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic [6:0]  list_length;
		int          item_no;
	} list_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_CLEAR;
	logic [5:0]  position = '0;
	logic [31:0] entry_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] read_value;
	logic [6:0]  list_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	// Local copy of the list, its length and the capacity register
	logic [31:0]  list_mem [DEPTH];
	int           list_count = 0;
	int           cap_limit = int'(CAPACITY_RESET);
	list_result_t pending_results [$];

	int mismatch_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int full_seen = 0;
	int badpos_seen = 0;
	int cap_writes = 0;
	int peak_length = 0;

	// Idle rates in percent; the result side rate changes only at an edge
	int   src_idle_pct = 6;
	int   snk_stall_pct = 52;
	logic hold_active = 1'b0;
	bit   holdoff_go = 1'b0;

	plan_row_t plan [PLAN_LEN] = '{
		// empty list after reset: nothing to read, clear is harmless
		'{1'b0, 7'd0, REQ_GET,    6'd0,  32'h0,        1'b1, ST_BADPOS, 32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_DELETE, 6'd63, 32'h0,        1'b1, ST_BADPOS, 32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_CLEAR,  6'd0,  32'h0,        1'b1, ST_OK,     32'h0, 7'd0},
		// insert far past the end appends
		'{1'b0, 7'd0, REQ_INSERT, 6'd63, 32'hFFFFFFFF, 1'b1, ST_OK,     32'h0, 7'd1},
		'{1'b0, 7'd0, REQ_INSERT, 6'd0,  32'h00000000, 1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd1,  32'hA5A5A5A5, 1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_GET,    6'd2,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_GET,    6'd3,  32'h0,        1'b1, ST_BADPOS, 32'h0, 7'd3},
		'{1'b0, 7'd0, REQ_DELETE, 6'd1,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_DELETE, 6'd1,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		// capacity one: the single entry fills the list
		'{1'b1, 7'd1, REQ_CLEAR,  6'd0,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd5,  32'h12345678, 1'b1, ST_FULL,   32'h0, 7'd1},
		'{1'b0, 7'd0, REQ_DELETE, 6'd0,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd0,  32'h5A5A5A5A, 1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd63, 32'hDEADBEEF, 1'b1, ST_FULL,   32'h0, 7'd1},
		// capacity zero: inserts fail, reads still work
		'{1'b1, 7'd0, REQ_CLEAR,  6'd0,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd0,  32'h0F0F0F0F, 1'b1, ST_FULL,   32'h0, 7'd1},
		'{1'b0, 7'd0, REQ_GET,    6'd0,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		// capacity above the depth saturates
		'{1'b1, 7'd127, REQ_CLEAR, 6'd0, 32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd63, 32'h80000000, 1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd0,  32'h00000001, 1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd2,  32'hFFFF0000, 1'b0, ST_OK,     32'h0, 7'd0},
		// capacity lowered below the count: inserts fail, deletes still work
		'{1'b1, 7'd2, REQ_CLEAR,  6'd0,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_INSERT, 6'd0,  32'h33333333, 1'b1, ST_FULL,   32'h0, 7'd4},
		'{1'b0, 7'd0, REQ_GET,    6'd3,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_DELETE, 6'd3,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0},
		'{1'b0, 7'd0, REQ_DELETE, 6'd63, 32'h0,        1'b1, ST_BADPOS, 32'h0, 7'd3},
		'{1'b0, 7'd0, REQ_CLEAR,  6'd9,  32'h0,        1'b1, ST_OK,     32'h0, 7'd0},
		'{1'b1, 7'd64, REQ_CLEAR, 6'd0,  32'h0,        1'b0, ST_OK,     32'h0, 7'd0}
	};

	positional_list_insert_delete #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (32)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.position    (position),
		.entry_value (entry_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.list_length (list_length),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one request to the local list and return the result it gives.
	function automatic list_result_t apply_request(input logic [1:0] req,
		input logic [5:0] pos, input logic [31:0] val);
		list_result_t res;
		int room;
		int slot;
		res.status = ST_OK;
		res.read_value = '0;
		res.item_no = 0;
		room = (cap_limit > DEPTH) ? DEPTH : cap_limit;
		slot = int'(pos);
		case (req)
			REQ_INSERT: begin
				if (list_count >= room) begin
					res.status = ST_FULL;
				end else begin
					// clamp past the end, then open a gap at the slot
					if (slot > list_count)
						slot = list_count;
					for (int i = list_count; i > slot; i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[slot] = val;
					list_count++;
				end
			end
			REQ_GET, REQ_DELETE: begin
				if (slot >= list_count) begin
					res.status = ST_BADPOS;
				end else begin
					res.read_value = list_mem[slot];
					if (req == REQ_DELETE) begin
						// close the gap over the valid entries only
						for (int i = slot; i + 1 < list_count; i++)
							list_mem[i] = list_mem[i + 1];
						list_count--;
					end
				end
			end
			default: begin
				list_count = 0;
			end
		endcase
		res.list_length = list_count[6:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int item_no,
		input logic [31:0] want, input logic [31:0] got);
		$display("mismatch at request %0d, %s: expected %0h, got %0h",
			item_no, what, want, got);
		mismatch_count++;
	endtask

	// Offer one request; idle first at the current rate, hold the payload
	// until the block takes it, then log its expected result.
	task automatic send_item(input plan_row_t row);
		list_result_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= row.req;
		position    <= row.pos;
		entry_value <= row.val;
		// sample the handshake mid-cycle, where every input has settled
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		predicted = apply_request(row.req, row.pos, row.val);
		if (row.typed) begin
			predicted.status      = row.st;
			predicted.read_value  = row.rd;
			predicted.list_length = row.len;
		end
		predicted.item_no = items_sent;
		pending_results.push_back(predicted);
		items_sent++;
		if (list_count > peak_length)
			peak_length = list_count;
	endtask

	// Write the capacity register once every pending result is back.
	task automatic write_capacity(input logic [6:0] cap);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		// let the two-stage result path run dry
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		cap_limit = int'(cap);
		cap_writes++;
	endtask

	// Random mix of requests; the rest of the hundred goes to clear.
	// Positions mostly land in or just past the list, sometimes anywhere.
	task automatic run_random(input int count, input int w_ins, input int w_get,
		input int w_del);
		plan_row_t row;
		int pick;
		for (int n = 0; n < count; n++) begin
			row = '0;
			pick = $urandom_range(99);
			if (pick < w_ins)
				row.req = REQ_INSERT;
			else if (pick < w_ins + w_get)
				row.req = REQ_GET;
			else if (pick < w_ins + w_get + w_del)
				row.req = REQ_DELETE;
			else
				row.req = REQ_CLEAR;
			if ($urandom_range(3) != 0)
				row.pos = 6'($urandom_range(list_count > 63 ? 63 : list_count));
			else
				row.pos = 6'($urandom_range(63));
			row.val = $urandom;
			send_item(row);
		end
	endtask

	// Result side: stall at the current rate, or solid during a hold-off
	always @(posedge clk) begin
		out_stall <= hold_active || ($urandom_range(99) < snk_stall_pct);
	end

	// Long hold-off on the result side, counted here, while requests keep
	// coming so that the block fills and stalls its input.
	initial begin : receiver_holdoff
		wait (holdoff_go);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// Check each result as it is taken against the oldest expectation
	always @(negedge clk) begin : result_check
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (status == ST_FULL)
				full_seen++;
			if (status == ST_BADPOS)
				badpos_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", -1, 32'h0, {30'h0, status});
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", want.item_no, 32'(want.status),
						32'(status));
				if (read_value !== want.read_value)
					report_mismatch("read_value", want.item_no, want.read_value, read_value);
				if (list_length !== want.list_length)
					report_mismatch("list_length", want.item_no, 32'(want.list_length),
						32'(list_length));
			end
		end
	end

	initial begin : run_limit
		#(LIMIT_NS * 1ns);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		// hold reset, then release it away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan, sender idles lightly, receiver stalls often
		for (int r = 0; r < PLAN_LEN; r++) begin
			if (plan[r].is_cfg)
				write_capacity(plan[r].cap);
			else
				send_item(plan[r]);
		end

		// fill to the full depth, then churn it
		run_random(100, 85, 8, 7);
		run_random(60, 30, 35, 30);

		// small capacity; swap the idle rates
		write_capacity(7'($urandom_range(1, 8)));
		src_idle_pct = 52;
		snk_stall_pct <= 6;
		run_random(150, 40, 25, 30);

		// saturated capacity, no idling, one long hold-off on the result side
		write_capacity(7'd127);
		src_idle_pct = 0;
		snk_stall_pct <= 0;
		run_random(10, 85, 10, 5);
		holdoff_go = 1'b1;
		run_random(90, 80, 10, 10);

		// any capacity the register holds, often below the current count
		write_capacity(7'($urandom_range(0, 127)));
		run_random(120, 35, 25, 35);

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d results: %0d full, %0d bad position",
			items_sent, results_seen, full_seen, badpos_seen);
		$display("capacity written %0d times, list reached %0d entries",
			cap_writes, peak_length);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
